[src/adaptive_duplicate_frame_check_scheduler_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the duplicate frame check scheduler
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_DUPLICATE_FRAME_CHECK_SCHEDULER_UNIT_DEFINES_SVH
`define ADAPTIVE_DUPLICATE_FRAME_CHECK_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ADFCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ADFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/adfcs_pkg.sv]
// ---------------------------------------------------------------------------
// adfcs_pkg
// Types, codes and constants shared by the duplicate frame check scheduler.
// ---------------------------------------------------------------------------
package adfcs_pkg;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned WIN_W      = 5;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [WIN_W-1:0] INITIAL_CHECK_FRAMES = 5'd16;
  localparam logic [WIN_W-1:0] MAX_SKIP_FRAMES      = 5'd16;

  // Frame status codes.
  localparam logic [1:0] ST_NEW  = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Detection modes.
  localparam logic [1:0] MODE_NEVER   = 2'd0;
  localparam logic [1:0] MODE_ALWAYS  = 2'd1;
  localparam logic [1:0] MODE_DYNAMIC = 2'd2;

  // Register indexes (word address).
  localparam logic [1:0] REG_DETECT_MODE  = 2'd0;
  localparam logic [1:0] REG_FORCE_DETECT = 2'd1;
  localparam logic [1:0] REG_GAME_MODE_3D = 2'd2;
  localparam logic [1:0] REG_STATS_ENABLE = 2'd3;

  typedef struct packed {
    logic [1:0] detect_mode;
    logic       force_detect;
    logic       game_mode_3d;
    logic       stats_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       source_status;
    logic [SEQ_W-1:0] capture_sequence;
    logic             frame_matches_previous;
    logic             store_setup_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]       frame_status;
    logic             copy_to_previous;
    logic             compare_used;
    logic [CNT_W-1:0] mispredict_total;
    logic [CNT_W-1:0] frame_total;
  } result_t;

  // Length of the checking window that follows a skipping window:
  // (78 - 4*s) / 7 truncated toward zero, kept to five bits.
  function automatic logic [WIN_W-1:0] check_window_len(input logic [WIN_W-1:0] skip_len);
    logic [WIN_W-1:0] len;
    unique case (skip_len)
      5'd0:                len = 5'd11;
      5'd1, 5'd2:          len = 5'd10;
      5'd3:                len = 5'd9;
      5'd4, 5'd5:          len = 5'd8;
      5'd6, 5'd7:          len = 5'd7;
      5'd8, 5'd9:          len = 5'd6;
      5'd10:               len = 5'd5;
      5'd11, 5'd12:        len = 5'd4;
      5'd13, 5'd14:        len = 5'd3;
      5'd15, 5'd16:        len = 5'd2;
      5'd17:               len = 5'd1;
      5'd18, 5'd19, 5'd20,
      5'd21:               len = 5'd0;
      5'd22:               len = 5'd31;
      5'd23, 5'd24:        len = 5'd30;
      5'd25, 5'd26:        len = 5'd29;
      5'd27, 5'd28:        len = 5'd28;
      5'd29:               len = 5'd27;
      5'd30, 5'd31:        len = 5'd26;
    endcase
    return len;
  endfunction

endpackage

[src/adfcs_cfg.sv]
// ---------------------------------------------------------------------------
// adfcs_cfg
// APB-style register file holding the detection mode and override controls.
// ---------------------------------------------------------------------------
module adfcs_cfg
  import adfcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_mode  <= MODE_DYNAMIC;
      cfg_r.force_detect <= 1'b0;
      cfg_r.game_mode_3d <= 1'b0;
      cfg_r.stats_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_DETECT_MODE:  cfg_r.detect_mode  <= pwdata[1:0];
        REG_FORCE_DETECT: cfg_r.force_detect <= pwdata[0];
        REG_GAME_MODE_3D: cfg_r.game_mode_3d <= pwdata[0];
        REG_STATS_ENABLE: cfg_r.stats_enable <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_DETECT_MODE:  prdata[1:0] = cfg_r.detect_mode;
      REG_FORCE_DETECT: prdata[0]   = cfg_r.force_detect;
      REG_GAME_MODE_3D: prdata[0]   = cfg_r.game_mode_3d;
      REG_STATS_ENABLE: prdata[0]   = cfg_r.stats_enable;
    endcase
  end

endmodule

[src/adfcs_core.sv]
// ---------------------------------------------------------------------------
// adfcs_core
// Per-frame decision logic with the schedule state and statistics counters.
// ---------------------------------------------------------------------------
`include "adaptive_duplicate_frame_check_scheduler_unit_defines.svh"

module adfcs_core
  import adfcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [SEQ_W-1:0] last_seq_r, last_seq_nxt;
  logic             store_valid_r, store_valid_nxt;
  logic             chk_phase_r, chk_phase_nxt;
  logic [WIN_W-1:0] rem_r, rem_nxt;
  logic [WIN_W-1:0] skip_r, skip_nxt;
  logic [CNT_W-1:0] mis_cnt_r, mis_cnt_nxt;
  logic [CNT_W-1:0] frm_cnt_r, frm_cnt_nxt;

  logic [1:0]       status;
  logic [WIN_W-1:0] rem_dec;
  logic             new_seq;
  logic             disabled;
  logic             always_check;
  logic             match;
  logic             stats;

  // Reserved status code three is folded into error.
  assign status       = item.source_status[1] ? ST_ERR : item.source_status;
  assign match        = item.frame_matches_previous;
  assign stats        = cfg.stats_enable;
  assign new_seq      = (status == ST_NEW) && (item.capture_sequence != last_seq_r);
  assign disabled     = !cfg.force_detect &&
                        (cfg.game_mode_3d || (cfg.detect_mode == MODE_NEVER));
  assign always_check = cfg.force_detect || (cfg.detect_mode == MODE_ALWAYS);
  assign rem_dec      = rem_r - 5'd1;

  always_comb begin
    last_seq_nxt    = last_seq_r;
    store_valid_nxt = store_valid_r;
    chk_phase_nxt   = chk_phase_r;
    rem_nxt         = rem_r;
    skip_nxt        = skip_r;
    mis_cnt_nxt     = mis_cnt_r;
    frm_cnt_nxt     = frm_cnt_r;

    res.frame_status     = status;
    res.copy_to_previous = 1'b0;
    res.compare_used     = 1'b0;

    // A new capture sequence restarts the schedule whatever follows.
    if (new_seq) begin
      last_seq_nxt         = item.capture_sequence;
      chk_phase_nxt        = 1'b1;
      rem_nxt              = INITIAL_CHECK_FRAMES;
      skip_nxt             = 5'd1;
      res.copy_to_previous = store_valid_r;
    end

    priority if ((status != ST_NEW) || (new_seq && store_valid_r) || disabled) begin
      // Frame is passed through as it is.
    end else if (!store_valid_r) begin
      res.frame_status = ST_NEW;
      if (item.store_setup_ok) begin
        store_valid_nxt      = 1'b1;
        res.copy_to_previous = 1'b1;
      end
    end else if (always_check) begin
      res.compare_used     = 1'b1;
      res.frame_status     = match ? ST_WAIT : ST_NEW;
      res.copy_to_previous = !match;
    end else if (chk_phase_r) begin
      res.compare_used = 1'b1;
      if (rem_dec == '0) begin
        chk_phase_nxt = 1'b0;
        rem_nxt       = skip_r;
        if (skip_r < MAX_SKIP_FRAMES) begin
          skip_nxt = skip_r + 5'd1;
        end
      end else begin
        rem_nxt = rem_dec;
      end
      if (match) begin
        // A duplicate during checking starts a fresh checking window.
        chk_phase_nxt        = 1'b1;
        rem_nxt              = INITIAL_CHECK_FRAMES;
        skip_nxt             = 5'd1;
        res.frame_status     = ST_WAIT;
        res.copy_to_previous = 1'b0;
      end else begin
        res.frame_status     = ST_NEW;
        res.copy_to_previous = (rem_dec != '0) || stats;
      end
    end else begin
      res.frame_status = ST_NEW;
      if (rem_dec == '0) begin
        chk_phase_nxt        = 1'b1;
        rem_nxt              = check_window_len(skip_r);
        res.copy_to_previous = !stats;
      end else begin
        rem_nxt = rem_dec;
      end
      if (stats) begin
        res.compare_used = 1'b1;
        if (match) begin
          mis_cnt_nxt = mis_cnt_r + 32'd1;
        end else begin
          res.copy_to_previous = 1'b1;
        end
        frm_cnt_nxt = frm_cnt_r + 32'd1;
      end
    end

    res.mispredict_total = mis_cnt_nxt;
    res.frame_total      = frm_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r    <= '0;
      store_valid_r <= 1'b0;
      chk_phase_r   <= 1'b0;
      rem_r         <= INITIAL_CHECK_FRAMES;
      skip_r        <= 5'd1;
      mis_cnt_r     <= '0;
      frm_cnt_r     <= '0;
    end else if (fire) begin
      last_seq_r    <= last_seq_nxt;
      store_valid_r <= store_valid_nxt;
      chk_phase_r   <= chk_phase_nxt;
      rem_r         <= rem_nxt;
      skip_r        <= skip_nxt;
      mis_cnt_r     <= mis_cnt_nxt;
      frm_cnt_r     <= frm_cnt_nxt;
    end
  end

  `ADFCS_ASSERT_NOW(a_rem_nonzero, 1'b1, rem_r != '0, "window counter reached zero")
  `ADFCS_ASSERT_NOW(a_skip_range, 1'b1, (skip_r != '0) && (skip_r <= MAX_SKIP_FRAMES), "skip length out of range")
  `ADFCS_ASSERT_NOW(a_cmp_needs_store, fire && res.compare_used, store_valid_r, "compare without a stored frame")
  `ADFCS_ASSERT_NOW(a_copy_is_new, fire && res.copy_to_previous, res.frame_status == ST_NEW, "copy on a frame that is not new")

endmodule

[src/adaptive_duplicate_frame_check_scheduler_unit.sv]
// Path: a transaction accepted into the input register is decided by the core and shows
// at the output once it has been loaded into the result register.
// Throughput: one frame event per cycle; the decision and state update fit in one stage.
// Output stalls back up through the input register to in_ready.
// Reset (rst_n low, synchronous) empties both stages, clears the schedule and counters,
// and loads the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
// adaptive_duplicate_frame_check_scheduler_unit
// Top level: input register, decision core, result register and APB registers.
// ---------------------------------------------------------------------------
`include "adaptive_duplicate_frame_check_scheduler_unit_defines.svh"

module adaptive_duplicate_frame_check_scheduler_unit
  import adfcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_source_status,
  input  logic [SEQ_W-1:0]      in_capture_sequence,
  input  logic                  in_frame_matches_previous,
  input  logic                  in_store_setup_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_frame_status,
  output logic                  out_copy_to_previous,
  output logic                  out_compare_used,
  output logic [CNT_W-1:0]      out_mispredict_total,
  output logic [CNT_W-1:0]      out_frame_total,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_vld_r;
  logic    s1_adv;
  logic    in_fire;
  result_t res;
  result_t out_res_r;
  logic    out_vld_r;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  adfcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.source_status          <= in_source_status;
      s1_item_r.capture_sequence       <= in_capture_sequence;
      s1_item_r.frame_matches_previous <= in_frame_matches_previous;
      s1_item_r.store_setup_ok         <= in_store_setup_ok;
    end
  end

  adfcs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (s1_adv),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_frame_status     = out_res_r.frame_status;
  assign out_copy_to_previous = out_res_r.copy_to_previous;
  assign out_compare_used     = out_res_r.compare_used;
  assign out_mispredict_total = out_res_r.mispredict_total;
  assign out_frame_total      = out_res_r.frame_total;

  `ADFCS_ASSERT_NEXT(a_s1_holds, s1_vld_r && !s1_adv, s1_vld_r, "stalled input lost")
  `ADFCS_ASSERT_NOW(a_no_overrun, in_fire && s1_vld_r, s1_adv, "input stage overwritten")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive duplicate frame check scheduler.
// Frame events go in over a valid/ready channel with random gaps and each
// result is compared field by field against an in-bench model of the
// check/skip schedule. The settings are changed over APB only while the unit
// is idle.
// ---------------------------------------------------------------------------
module tb;
  import adfcs_pkg::*;

  localparam logic [1:0] MODE_DYNAMIC_ALT = 2'd3;  // unused mode code, acts as dynamic
  localparam logic [1:0] ST_ERR_ALIAS     = 2'd3;  // unused status code, acts as error
  localparam int         WATCHDOG_LIMIT   = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_source_status = '0;
  logic [SEQ_W-1:0]      in_capture_sequence = '0;
  logic                  in_frame_matches_previous = 1'b0;
  logic                  in_store_setup_ok = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_frame_status;
  logic                  out_copy_to_previous;
  logic                  out_compare_used;
  logic [CNT_W-1:0]      out_mispredict_total;
  logic [CNT_W-1:0]      out_frame_total;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  adaptive_duplicate_frame_check_scheduler_unit dut (.*);

  always #1 clk = ~clk;

  // Tracks the check/skip schedule and holds the decisions still owed by the unit.
  class dedup_scoreboard;
    cfg_t             regs;
    logic [SEQ_W-1:0] last_seq;
    logic             store_valid;
    logic             checking;
    logic [WIN_W-1:0] remaining;
    logic [WIN_W-1:0] next_skip;
    logic [CNT_W-1:0] mispredicts;
    logic [CNT_W-1:0] skip_frames;
    result_t          decisions_q[$];
    int               mismatches;

    function new();
      regs.detect_mode  = MODE_DYNAMIC;
      regs.force_detect = 1'b0;
      regs.game_mode_3d = 1'b0;
      regs.stats_enable = 1'b0;
      last_seq    = '0;
      store_valid = 1'b0;
      checking    = 1'b0;
      remaining   = INITIAL_CHECK_FRAMES;
      next_skip   = 5'd1;
      mispredicts = '0;
      skip_frames = '0;
      mismatches  = 0;
    endfunction

    function void restart();
      checking  = 1'b1;
      remaining = INITIAL_CHECK_FRAMES;
      next_skip = 5'd1;
    endfunction

    function void push(logic [1:0] st, logic copy, logic cmp);
      result_t r;
      r.frame_status     = st;
      r.copy_to_previous = copy;
      r.compare_used     = cmp;
      r.mispredict_total = mispredicts;
      r.frame_total      = skip_frames;
      decisions_q.push_back(r);
    endfunction

    function void write_reg(logic [1:0] idx, logic [1:0] val);
      case (idx)
        REG_DETECT_MODE:  regs.detect_mode  = val;
        REG_FORCE_DETECT: regs.force_detect = val[0];
        REG_GAME_MODE_3D: regs.game_mode_3d = val[0];
        REG_STATS_ENABLE: regs.stats_enable = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return decisions_q.size();
    endfunction

    function void note_frame(item_t f);
      logic [1:0] st;
      logic       fresh;
      logic       copy;
      logic       disabled;
      int         len;
      st = (f.source_status == ST_ERR_ALIAS) ? ST_ERR : f.source_status;
      copy = 1'b0;
      fresh = (st == ST_NEW) && (f.capture_sequence != last_seq);
      if (fresh) begin
        last_seq = f.capture_sequence;
        restart();
        if (store_valid) copy = 1'b1;
      end
      disabled = !regs.force_detect &&
                 (regs.game_mode_3d || regs.detect_mode == MODE_NEVER);
      if (st != ST_NEW || (fresh && store_valid) || disabled) begin
        push(st, copy, 1'b0);
      end else if (!store_valid) begin
        if (f.store_setup_ok) begin
          store_valid = 1'b1;
          copy = 1'b1;
        end
        push(ST_NEW, copy, 1'b0);
      end else if (regs.force_detect || regs.detect_mode == MODE_ALWAYS) begin
        if (f.frame_matches_previous) push(ST_WAIT, 1'b0, 1'b1);
        else push(ST_NEW, 1'b1, 1'b1);
      end else if (checking) begin
        remaining = remaining - 1'b1;
        if (remaining == '0) begin
          checking  = 1'b0;
          remaining = next_skip;
          if (next_skip < MAX_SKIP_FRAMES) next_skip = next_skip + 1'b1;
        end
        if (f.frame_matches_previous) begin
          restart();
          push(ST_WAIT, 1'b0, 1'b1);
        end else begin
          push(ST_NEW, checking || regs.stats_enable, 1'b1);
        end
      end else begin
        remaining = remaining - 1'b1;
        if (remaining == '0) begin
          // The next checking window shrinks as the skip length grows.
          len = (78 - 4 * int'(next_skip)) / 7;
          checking  = 1'b1;
          remaining = WIN_W'(len);
          if (!regs.stats_enable) copy = 1'b1;
        end
        if (regs.stats_enable) begin
          if (f.frame_matches_previous) mispredicts = mispredicts + 1'b1;
          else copy = 1'b1;
          skip_frames = skip_frames + 1'b1;
          push(ST_NEW, copy, 1'b1);
        end else begin
          push(ST_NEW, copy, 1'b0);
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (decisions_q.size() == 0) begin
        $error("result transaction with no frame outstanding");
        mismatches++;
        return;
      end
      want = decisions_q.pop_front();
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
        mismatches++;
      end
      if (got.copy_to_previous !== want.copy_to_previous) begin
        $error("copy_to_previous: expected %0d, got %0d",
               want.copy_to_previous, got.copy_to_previous);
        mismatches++;
      end
      if (got.compare_used !== want.compare_used) begin
        $error("compare_used: expected %0d, got %0d", want.compare_used, got.compare_used);
        mismatches++;
      end
      if (got.mispredict_total !== want.mispredict_total) begin
        $error("mispredict_total: expected %0d, got %0d",
               want.mispredict_total, got.mispredict_total);
        mismatches++;
      end
      if (got.frame_total !== want.frame_total) begin
        $error("frame_total: expected %0d, got %0d", want.frame_total, got.frame_total);
        mismatches++;
      end
    endfunction
  endclass

  dedup_scoreboard  sb = new();
  int               tx_gap_max = 16;
  int               rx_stall_max = 16;
  logic [SEQ_W-1:0] cur_seq = '0;
  int               idle_cycles = 0;

  // All driving tasks start and end just after a falling edge.
  task automatic send_frame(input item_t f);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid                  <= 1'b1;
    in_source_status          <= f.source_status;
    in_capture_sequence       <= f.capture_sequence;
    in_frame_matches_previous <= f.frame_matches_previous;
    in_store_setup_ok         <= f.store_setup_ok;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(f);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [1:0] st, input logic [SEQ_W-1:0] seq,
                             input logic match, input logic setup_ok);
    item_t f;
    f.source_status          = st;
    f.capture_sequence       = seq;
    f.frame_matches_previous = match;
    f.store_setup_ok         = setup_ok;
    send_frame(f);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic frc, input logic g3d,
                            input logic stats);
    wait_drained();
    apb_write(REG_DETECT_MODE, mode);
    apb_write(REG_FORCE_DETECT, {1'b0, frc});
    apb_write(REG_GAME_MODE_3D, {1'b0, g3d});
    apb_write(REG_STATS_ENABLE, {1'b0, stats});
  endtask

  // Mostly a steady capture session with random compare results, plus stray
  // waiting/error events and occasional new sessions.
  task automatic run_phase(input logic [1:0] mode, input logic frc, input logic g3d,
                           input logic stats, input int count, input int match_pct,
                           input int newseq_pct);
    item_t f;
    set_config(mode, frc, g3d, stats);
    tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 16;
    rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      if ($urandom_range(0, 99) < 8) begin
        f.source_status    = 2'($urandom_range(1, 3));
        f.capture_sequence = $urandom;
      end else begin
        if ($urandom_range(0, 99) < newseq_pct) cur_seq = $urandom;
        f.source_status    = ST_NEW;
        f.capture_sequence = cur_seq;
      end
      f.frame_matches_previous = ($urandom_range(0, 99) < match_pct);
      f.store_setup_ok         = ($urandom_range(0, 9) != 0);
      send_frame(f);
    end
  endtask

  initial begin
    wait (rst_n);
    @(negedge clk);
    forever begin
      int stall;
      result_t got;
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {out_frame_status, out_copy_to_previous, out_compare_used,
             out_mispredict_total, out_frame_total};
      sb.check_result(got);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: dynamic mode, no previous frame stored yet.
    send_fields(ST_NEW, 32'h0, 1'b0, 1'b0);
    send_fields(ST_ERR_ALIAS, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_fields(ST_WAIT, 32'h5, 1'b1, 1'b0);
    send_fields(ST_ERR, 32'hA5A5_5A5A, 1'b0, 1'b1);
    send_fields(ST_NEW, 32'h0, 1'b0, 1'b1);
    send_fields(ST_NEW, 32'h0, 1'b1, 1'b1);
    send_fields(ST_NEW, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_fields(ST_NEW, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_fields(ST_NEW, 32'hFFFF_FFFF, 1'b0, 1'b0);
    set_config(MODE_ALWAYS, 1'b0, 1'b0, 1'b0);
    send_fields(ST_NEW, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_fields(ST_NEW, 32'hFFFF_FFFF, 1'b0, 1'b1);
    set_config(MODE_NEVER, 1'b0, 1'b0, 1'b0);
    send_fields(ST_NEW, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_fields(ST_NEW, 32'h8000_0001, 1'b0, 1'b1);
    set_config(MODE_NEVER, 1'b1, 1'b0, 1'b0);
    send_fields(ST_NEW, 32'h8000_0001, 1'b1, 1'b1);
    set_config(MODE_NEVER, 1'b1, 1'b1, 1'b0);
    send_fields(ST_NEW, 32'h8000_0001, 1'b0, 1'b1);
    set_config(MODE_DYNAMIC, 1'b0, 1'b1, 1'b0);
    send_fields(ST_NEW, 32'h8000_0001, 1'b1, 1'b1);
    send_fields(ST_NEW, 32'h7FFF_FFFE, 1'b1, 1'b0);
    set_config(MODE_DYNAMIC_ALT, 1'b0, 1'b0, 1'b1);
    send_fields(ST_NEW, 32'h2, 1'b0, 1'b1);
    send_fields(ST_NEW, 32'h2, 1'b0, 1'b1);
    send_fields(ST_NEW, 32'h2, 1'b1, 1'b0);
    send_fields(ST_NEW, 32'h2, 1'b0, 1'b1);
    cur_seq = 32'h2;

    // A long quiet session walks the schedule out to the longest skip window.
    run_phase(MODE_DYNAMIC, 1'b0, 1'b0, 1'b0, 300, 1, 0);
    run_phase(MODE_DYNAMIC, 1'b0, 1'b0, 1'b1, 150, 15, 2);
    run_phase(MODE_ALWAYS, 1'b0, 1'b0, 1'b1, 60, 40, 3);
    run_phase(MODE_NEVER, 1'b0, 1'b0, 1'b0, 40, 30, 5);
    run_phase(MODE_DYNAMIC_ALT, 1'b0, 1'b0, 1'b1, 80, 3, 1);
    run_phase(MODE_NEVER, 1'b1, 1'b1, 1'b1, 40, 30, 5);
    run_phase(MODE_DYNAMIC, 1'b0, 1'b1, 1'b0, 30, 30, 5);
    run_phase(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom),
              50, 10, 2);

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/adfcs_pkg.sv
src/adfcs_cfg.sv
src/adfcs_core.sv
src/adaptive_duplicate_frame_check_scheduler_unit.sv
sim/tb.sv
